[hdl/twg_pkg.sv]
// Package for the table waveform generator.
// Holds field widths, register indexes, mode and state types and the waveform tables.
// No dependencies.
package twg_pkg;

    localparam int PERIOD_W        = 16;
    localparam int DUTY_W          = 7;
    localparam int POS_W           = 6;
    localparam int NUM_W           = PERIOD_W + DUTY_W;
    localparam int ROM_LEN         = 53;
    localparam int ROM_AW          = 6;
    localparam int WIDE_IDX_W      = 8;
    localparam int TABLE_STEPS_DEF = 53;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 16;

    localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(100);
    localparam logic [DUTY_W-1:0] DUTY_ZERO = '0;

    localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_DC,
        MODE_SQUARE,
        MODE_SINE
    } wave_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } twg_state_t;

    localparam logic [DUTY_W-1:0] SINE_ROM [ROM_LEN] = '{
        7'd50, 7'd56, 7'd62, 7'd68, 7'd73, 7'd78, 7'd83, 7'd87, 7'd91, 7'd94,
        7'd97, 7'd98, 7'd100, 7'd100, 7'd100, 7'd99, 7'd97, 7'd95, 7'd92, 7'd88,
        7'd84, 7'd79, 7'd74, 7'd69, 7'd63, 7'd57, 7'd51, 7'd45, 7'd39, 7'd33,
        7'd28, 7'd23, 7'd18, 7'd13, 7'd10, 7'd6, 7'd4, 7'd2, 7'd1, 7'd0,
        7'd0, 7'd1, 7'd3, 7'd5, 7'd8, 7'd11, 7'd15, 7'd20, 7'd25, 7'd30,
        7'd36, 7'd42, 7'd48
    };

    // first 27 entries of the square table are full scale, the rest zero
    localparam int SQUARE_HIGH_LEN = 27;

    // table address: index modulo the table length (index is below 256)
    function automatic logic [ROM_AW-1:0] rom_addr(input logic [WIDE_IDX_W-1:0] i);
        logic [WIDE_IDX_W-1:0] r;
        r = i;
        for (int k = 0; k < 4; k++) begin
            if (r >= WIDE_IDX_W'(ROM_LEN)) begin
                r = r - WIDE_IDX_W'(ROM_LEN);
            end
        end
        return r[ROM_AW-1:0];
    endfunction

    function automatic logic [DUTY_W-1:0] sine_lut(input logic [ROM_AW-1:0] a);
        logic [DUTY_W-1:0] v;
        v = DUTY_ZERO;
        if (a < ROM_AW'(ROM_LEN)) begin
            v = SINE_ROM[a];
        end
        return v;
    endfunction

    function automatic logic [DUTY_W-1:0] square_lut(input logic [ROM_AW-1:0] a);
        return (a < ROM_AW'(SQUARE_HIGH_LEN)) ? DUTY_FULL : DUTY_ZERO;
    endfunction

endpackage

[hdl/twg_mul.sv]
// Bit-serial weighted sum s0*w0 + s1*w1, one bit of the sample values per cycle.
// Depends on twg_pkg.
module twg_mul (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [twg_pkg::DUTY_W-1:0]     s0,
    input  logic [twg_pkg::DUTY_W-1:0]     s1,
    input  logic [twg_pkg::PERIOD_W-1:0]   w0,
    input  logic [twg_pkg::PERIOD_W-1:0]   w1,
    output logic                           done,
    output logic [twg_pkg::NUM_W-1:0]      product
);
    import twg_pkg::*;

    localparam int CNT_W = $clog2(DUTY_W + 1);

    logic [DUTY_W-1:0]   s0_reg, s0_next, s1_reg, s1_next;
    logic [PERIOD_W-1:0] w0_reg, w0_next, w1_reg, w1_next;
    logic [NUM_W-1:0]    acc_reg, acc_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    always_comb begin
        s0_next   = s0_reg;
        s1_next   = s1_reg;
        w0_next   = w0_reg;
        w1_next   = w1_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            s0_next   = s0;
            s1_next   = s1;
            w0_next   = w0;
            w1_next   = w1;
            acc_next  = '0;
            cnt_next  = CNT_W'(DUTY_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // MSB first: shift the partial sum, add the selected weights
            acc_next = (acc_reg << 1)
                     + (s0_reg[DUTY_W-1] ? NUM_W'(w0_reg) : '0)
                     + (s1_reg[DUTY_W-1] ? NUM_W'(w1_reg) : '0);
            s0_next  = s0_reg << 1;
            s1_next  = s1_reg << 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        s0_reg  <= s0_next;
        s1_reg  <= s1_next;
        w0_reg  <= w0_next;
        w1_reg  <= w1_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[hdl/twg_div.sv]
// Restoring divider, one quotient bit per cycle, quotient fits DUTY_W bits.
// Depends on twg_pkg.
module twg_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [twg_pkg::NUM_W-1:0]      num,
    input  logic [twg_pkg::PERIOD_W-1:0]   den,
    output logic                           done,
    output logic [twg_pkg::DUTY_W-1:0]     quot
);
    import twg_pkg::*;

    localparam int CNT_W = $clog2(DUTY_W + 1);

    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  dsh_reg, dsh_next;
    logic [DUTY_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    always_comb begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = num;
            dsh_next  = NUM_W'(den) << (DUTY_W - 1);
            q_next    = '0;
            cnt_next  = CNT_W'(DUTY_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg >= dsh_reg) begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[DUTY_W-2:0], 1'b1};
            end else begin
                q_next   = {q_reg[DUTY_W-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

[hdl/table_waveform_generator.sv]
// Table waveform generator, top level.
// Depends on twg_pkg, twg_mul and twg_div.
//
// Usage:
//   cfg channel : cfg_index 0 writes the wave mode (none, dc, square, sine),
//                 cfg_index 1 writes the step period in ticks. Always ready;
//                 write only while no transaction is in flight.
//   s channel   : one transaction per timer tick (s_tick). The tick counter
//                 advances and, on reaching the step period, clears and moves
//                 the table index on, wrapping after the last step.
//   m channel   : one transaction per input: PWM duty in percent and the
//                 table index after the tick.
// Path: in interpolated sine mode an input transaction passes the load state,
//   the bit-serial weighted sum and the bit-serial division, then the done
//   state into the output register; in the other modes, and in sine mode with
//   a zero period or a count not below the period, load goes straight to done.
// Flow: one item at a time; s_ready returns in the same cycle that m_valid is set.
// Reset: mode none, period 1, counter and index zero, no result pending.
// Stall: the result sits in an output register; the next tick is still
//   accepted and computed, and it waits in the final state until the
//   output register is taken.
module table_waveform_generator #(
    parameter int TABLE_STEPS = twg_pkg::TABLE_STEPS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [twg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [twg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_tick,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [twg_pkg::DUTY_W-1:0]       m_duty_percent,
    output logic [twg_pkg::POS_W-1:0]        m_table_position
);
    import twg_pkg::*;

    localparam int IDX_W = (TABLE_STEPS > 1) ? $clog2(TABLE_STEPS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_STEPS - 1);

    // configuration registers
    wave_mode_t          mode_reg, mode_next;
    logic [PERIOD_W-1:0] period_reg, period_next;

    // tick counter and table index
    logic [PERIOD_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [PERIOD_W-1:0] count_inc;
    logic [IDX_W-1:0]    idx_step;

    twg_state_t state_reg, state_next;

    // result staging and output register
    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic [DUTY_W-1:0] duty_out_reg, duty_out_next;
    logic [POS_W-1:0]  pos_out_reg, pos_out_next;
    logic              m_valid_reg, m_valid_next;

    // control decoded from state
    logic in_take, mul_start, div_start, load_direct, load_out, out_free;

    // table lookup path
    logic [IDX_W+WIDE_IDX_W-1:0] idx_ext, nidx_ext;
    logic [IDX_W+POS_W-1:0]      pos_ext;
    logic [ROM_AW-1:0]           addr0, addr1;
    logic [DUTY_W-1:0]           s0, s1, direct_duty;
    logic                        interp;
    logic [PERIOD_W-1:0]         w0;

    logic              mul_done, div_done;
    logic [NUM_W-1:0]  mul_product;
    logic [DUTY_W-1:0] div_quot;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        mode_next   = mode_reg;
        period_next = period_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_WAVE_MODE:   mode_next   = wave_mode_t'(cfg_data[1:0]);
                REG_STEP_PERIOD: period_next = cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // counter update on each accepted tick
    assign idx_step  = (idx_reg == IDX_LAST) ? '0 : idx_reg + IDX_W'(1);
    assign count_inc = count_reg + PERIOD_W'(1);

    always_comb begin
        count_next = count_reg;
        idx_next   = idx_reg;
        if (in_take && s_tick) begin
            if (count_inc >= period_reg) begin
                count_next = '0;
                idx_next   = idx_step;
            end else begin
                count_next = count_inc;
            end
        end
    end

    // table addresses of the current and next step
    assign idx_ext  = {{WIDE_IDX_W{1'b0}}, idx_reg};
    assign nidx_ext = {{WIDE_IDX_W{1'b0}}, idx_step};
    assign pos_ext  = {{POS_W{1'b0}}, idx_reg};
    assign addr0    = rom_addr(idx_ext[WIDE_IDX_W-1:0]);
    assign addr1    = rom_addr(nidx_ext[WIDE_IDX_W-1:0]);
    assign s0       = sine_lut(addr0);
    assign s1       = sine_lut(addr1);

    // interpolate only when the count sits inside a nonzero period
    assign interp = (mode_reg == MODE_SINE) && (period_reg != '0) && (count_reg < period_reg);
    assign w0     = period_reg - count_reg;

    always_comb begin
        case (mode_reg)
            MODE_DC:     direct_duty = DUTY_FULL;
            MODE_SQUARE: direct_duty = square_lut(addr0);
            MODE_SINE:   direct_duty = s0;
            default:     direct_duty = DUTY_ZERO;
        endcase
    end

    // next-state logic
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_LOAD;
            ST_LOAD: state_next = interp ? ST_MUL : ST_DONE;
            ST_MUL:  if (mul_done) state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs of the state machine
    always_comb begin
        s_ready     = 1'b0;
        mul_start   = 1'b0;
        div_start   = 1'b0;
        load_direct = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_LOAD: begin
                mul_start   = interp;
                load_direct = !interp;
            end
            ST_MUL:  div_start = mul_done;
            ST_DONE: load_out = out_free;
            default: ;
        endcase
    end

    assign in_take = s_valid && s_ready;

    always_comb begin
        duty_next = duty_reg;
        if (load_direct) begin
            duty_next = direct_duty;
        end else if (state_reg == ST_DIV && div_done) begin
            duty_next = div_quot;
        end
    end

    always_comb begin
        duty_out_next = duty_out_reg;
        pos_out_next  = pos_out_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        if (load_out) begin
            duty_out_next = duty_reg;
            pos_out_next  = pos_ext[POS_W-1:0];
            m_valid_next  = 1'b1;
        end
    end

    twg_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .s0      (s0),
        .s1      (s1),
        .w0      (w0),
        .w1      (count_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    twg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (mul_product),
        .den     (period_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_NONE;
            period_reg  <= PERIOD_W'(1);
            count_reg   <= '0;
            idx_reg     <= '0;
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            mode_reg    <= mode_next;
            period_reg  <= period_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        duty_reg     <= duty_next;
        duty_out_reg <= duty_out_next;
        pos_out_reg  <= pos_out_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_duty_percent   = duty_out_reg;
    assign m_table_position = pos_out_reg;

endmodule

[hdl/twg_checker.sv]
// Port-level checks for the table waveform generator, bound to the top level.
// Depends on twg_pkg and table_waveform_generator.
module twg_checker #(
    parameter int TABLE_STEPS = twg_pkg::TABLE_STEPS_DEF
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [twg_pkg::DUTY_W-1:0]       m_duty_percent,
    input logic [twg_pkg::POS_W-1:0]        m_table_position
);
    import twg_pkg::*;

    localparam int POS_SPAN = 1 << POS_W;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_duty_percent)
                                && $stable(m_table_position))
        else $error("result changed while stalled");

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_duty_percent <= DUTY_FULL)
        else $error("duty above full scale");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (TABLE_STEPS > POS_SPAN) || (32'(m_table_position) < TABLE_STEPS))
        else $error("table position out of range");

    // one tick in flight: input closes right after a transaction
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second tick taken while busy");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule

bind table_waveform_generator twg_checker #(.TABLE_STEPS(TABLE_STEPS)) u_twg_checker (.*);

[verif/table_waveform_generator_tb.sv]
// Self-checking testbench for table_waveform_generator: directed and random ticks
// against a cycle-free duty predictor, with random backpressure on the result channel.
// Depends on twg_pkg and the table_waveform_generator RTL.
`timescale 1ns / 1ps

module table_waveform_generator_tb;

    import twg_pkg::*;

    localparam int STEPS          = TABLE_STEPS_DEF;
    localparam int WATCHDOG_LIMIT = 2000;   // idle cycles, far above the HOLD_CYCLES receiver hold
    localparam int SETTLE_CYCLES  = 25;     // longer than the sine path through the weighted sum and the division
    localparam int HOLD_CYCLES    = 200;
    localparam int PHASE_COUNT    = 10;
    localparam int PHASE_TICKS    = 68;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [POS_W-1:0]  pos;
    } duty_sample_t;

    // DUT signals; the inputs are driven to known values from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic                  s_tick    = 1'b0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [DUTY_W-1:0]     m_duty_percent;
    logic [POS_W-1:0]      m_table_position;

    // Predictor state: shadow registers plus counter and table index
    wave_mode_t            cur_mode;
    logic [PERIOD_W-1:0]   cur_period;
    logic [PERIOD_W-1:0]   tick_count;
    int                    step_index;

    duty_sample_t          expected_duty_q[$];
    duty_sample_t          oldest;
    int                    errors         = 0;
    int                    stalled_cycles = 0;

    // Receiver controls: stall probability in percent, plus a one-shot long hold
    int                    stall_pct      = 0;
    bit                    hold_request   = 1'b0;
    int                    hold_left      = 0;

    table_waveform_generator uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_tick           (s_tick),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_duty_percent   (m_duty_percent),
        .m_table_position (m_table_position)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    //------------------------------------------------------------------
    // Duty predictor
    //------------------------------------------------------------------

    function automatic int next_index(input int i);
        return (i + 1 >= STEPS) ? 0 : i + 1;
    endfunction

    // Advances the counter/index for one accepted transaction and queues
    // the duty and table position the block must report for it.
    task automatic apply_tick(input logic tick);
        int           s0;
        int           s1;
        int           weighted;
        duty_sample_t e;
        if (tick) begin
            tick_count = tick_count + 1'b1;
            // also catches a count left above a freshly lowered period
            if (tick_count >= cur_period) begin
                tick_count = '0;
                step_index = next_index(step_index);
            end
        end
        case (cur_mode)
            MODE_DC: begin
                e.duty = DUTY_FULL;
            end
            MODE_SQUARE: begin
                e.duty = ((step_index % ROM_LEN) < SQUARE_HIGH_LEN) ? DUTY_FULL : DUTY_ZERO;
            end
            MODE_SINE: begin
                s0 = int'(SINE_ROM[step_index % ROM_LEN]);
                s1 = int'(SINE_ROM[next_index(step_index) % ROM_LEN]);
                // zero period, or count at/above period after a tick of zero: no division
                if (cur_period == '0 || tick_count >= cur_period) begin
                    e.duty = DUTY_W'(s0);
                end else begin
                    weighted = s0 * (int'(cur_period) - int'(tick_count))
                             + s1 * int'(tick_count);
                    e.duty = DUTY_W'(weighted / int'(cur_period));
                end
            end
            default: begin
                e.duty = DUTY_ZERO;
            end
        endcase
        e.pos = POS_W'(step_index);
        expected_duty_q.push_back(e);
    endtask

    //------------------------------------------------------------------
    // Channel drivers (inputs change on the falling edge)
    //------------------------------------------------------------------

    // Offer one tick; valid stays up afterwards so back-to-back sends keep it high.
    task automatic send_tick(input logic tick);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_tick  <= tick;
        do @(posedge aclk); while (!s_ready);
        apply_tick(tick);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            s_tick  <= 1'($urandom);
            repeat (cycles - 1) @(negedge aclk);
        end
    endtask

    // Stop offering and wait for every outstanding result, then let the
    // pipeline settle so a register write lands on an idle block.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_duty_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_WAVE_MODE) begin
            cur_mode = wave_mode_t'(data[1:0]);
        end else begin
            cur_period = data;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Upper data bits are noise; only the low two select the mode.
    task automatic write_mode(input wave_mode_t mode);
        write_register(REG_WAVE_MODE, {14'($urandom), mode});
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] period);
        write_register(REG_STEP_PERIOD, period);
    endtask

    // Random ticks in bursts; roughly one in ten carries tick = 0.
    task automatic random_ticks(input int count, input bit use_gaps);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < count; k++) begin
                send_tick($urandom_range(0, 9) != 0);
                sent++;
            end
            if (use_gaps) begin
                pause_sender($urandom_range(0, 6));
            end
        end
    endtask

    //------------------------------------------------------------------
    // Result receiver and checker
    //------------------------------------------------------------------

    // m_ready pattern: random stalls at stall_pct, or a long hold on request.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_duty_q.size() == 0) begin
                $error("unexpected transaction: duty_percent %0d table_position %0d",
                       m_duty_percent, m_table_position);
                errors++;
            end else begin
                oldest = expected_duty_q.pop_front();
                if (m_duty_percent !== oldest.duty) begin
                    $error("duty_percent: expected %0d, actual %0d",
                           oldest.duty, m_duty_percent);
                    errors++;
                end
                if (m_table_position !== oldest.pos) begin
                    $error("table_position: expected %0d, actual %0d",
                           oldest.pos, m_table_position);
                    errors++;
                end
            end
        end
    end

    // Watchdog: any handshake on any channel resets the idle count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles = stalled_cycles + 1;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("table_waveform_generator: mismatch");
                $finish;
            end
        end
    end

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Reset defaults: mode none, period 1, so every tick advances the index.
    task automatic test_reset_state();
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    task automatic test_fixed_modes();
        write_mode(MODE_DC);
        send_tick(1'b1);
        send_tick(1'b0);
        write_mode(MODE_SQUARE);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        write_mode(MODE_NONE);
        send_tick(1'b1);
    endtask

    // Zero period: index moves on every tick and sine reports s0 undivided.
    task automatic test_zero_period();
        write_mode(MODE_SINE);
        write_period('0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    // Largest period builds up a count, then the period drops below it:
    // a tick of zero must report s0, the next real tick clears and advances.
    task automatic test_period_lowered();
        write_period(16'hFFFF);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        write_period(16'd2);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
    endtask

    // Long receiver hold while the sender keeps going: the block fills
    // and must stall s_ready; then the sender waits for a full drain.
    task automatic test_back_pressure();
        write_period(16'd1);
        @(posedge aclk);
        hold_request = 1'b1;
        for (int k = 0; k < 10; k++) begin
            send_tick(1'b1);
        end
        wait_idle();
    endtask

    // Random phases: mode weighted toward sine, period mostly small so the
    // index wraps often, with a few large ones; idling varies per phase.
    task automatic test_random_phases();
        int mode_pick;
        int period_pick;
        logic [PERIOD_W-1:0] period;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            mode_pick = $urandom_range(0, 5);
            write_mode((mode_pick > 3) ? MODE_SINE : wave_mode_t'(mode_pick));
            period_pick = $urandom_range(0, 9);
            if (period_pick == 0) begin
                period = '0;
            end else if (period_pick <= 5) begin
                period = PERIOD_W'($urandom_range(1, 4));
            end else if (period_pick <= 7) begin
                period = PERIOD_W'($urandom_range(5, 40));
            end else if (period_pick == 8) begin
                period = PERIOD_W'($urandom_range(41, 65535));
            end else begin
                period = 16'hFFFF;
            end
            write_period(period);
            case (phase % 3)
                0: stall_pct = 0;
                1: stall_pct = 25;
                default: stall_pct = 60;
            endcase
            random_ticks(PHASE_TICKS, (phase % 4) != 0);
        end
        stall_pct = 0;
    endtask

    initial begin
        cur_mode   = MODE_NONE;
        cur_period = PERIOD_W'(1);
        tick_count = '0;
        step_index = 0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_fixed_modes();
        test_zero_period();
        test_period_lowered();
        test_back_pressure();
        test_random_phases();

        wait_idle();
        if (expected_duty_q.size() != 0) begin
            $error("%0d expected transactions never arrived", expected_duty_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("table_waveform_generator: match");
        end else begin
            $display("table_waveform_generator: mismatch");
        end
        $finish;
    end

endmodule
